>>> hw/rtl/ctd_pkg.sv
// ----------------------------------------------------------------------------
// Cartesian tree depth package
// Shared widths, word types and cell control for the depth chain.
// ----------------------------------------------------------------------------
package ctd_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 16;
	localparam int DEPTH_W    = 6;
	localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W      = $clog2(MAX_ITEMS);

	typedef struct packed {
		logic [15:0] value;
		logic        is_final;
	} ctd_in_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               end_of_run;
	} ctd_out_t;

	// A value moving along the chain, with a mark for an occupied position.
	typedef struct packed {
		logic                  vld;
		logic [VALUE_BITS-1:0] val;
	} ctd_stream_t;

	typedef struct packed {
		logic init;
		logic scan;
		logic drain;
	} ctd_ctl_t;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_INIT  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DRAIN = 4'b1000
	} ctd_state_t;

endpackage

>>> hw/rtl/ctd_cell.sv
// ----------------------------------------------------------------------------
// Cartesian tree depth cell
// Holds one position of the sequence and counts its ancestors while values
// stream past it in both directions.
// ----------------------------------------------------------------------------
module ctd_cell
	import ctd_pkg::*;
(
	input  logic                  clk,
	input  ctd_ctl_t              ctl,
	input  logic                  wr,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  logic                  occupied,
	input  ctd_stream_t           r_in,
	input  ctd_stream_t           l_in,
	input  logic [DEPTH_W-1:0]    depth_in,
	output ctd_stream_t           r_out,
	output ctd_stream_t           l_out,
	output logic [DEPTH_W-1:0]    depth_out
);

	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] max_l_q;
	logic [VALUE_BITS-1:0] max_r_q;
	ctd_stream_t           rs_q;
	ctd_stream_t           ls_q;
	logic [DEPTH_W-1:0]    depth_q;
	logic                  inc_l;
	logic                  inc_r;

	// Ties go to the leftmost position, so a left neighbor wins on equal.
	assign inc_l = r_in.vld && (r_in.val >= max_l_q);
	assign inc_r = l_in.vld && (l_in.val > max_r_q);

	always_ff @(posedge clk) begin
		if (wr) begin
			val_q <= wr_value;
		end
		if (ctl.init) begin
			rs_q    <= '{vld: occupied, val: val_q};
			ls_q    <= '{vld: occupied, val: val_q};
			max_l_q <= val_q;
			max_r_q <= val_q;
			depth_q <= '0;
		end else if (ctl.scan) begin
			rs_q    <= r_in;
			ls_q    <= l_in;
			if (inc_l) begin
				max_l_q <= r_in.val;
			end
			if (inc_r) begin
				max_r_q <= l_in.val;
			end
			depth_q <= depth_q + DEPTH_W'(inc_l) + DEPTH_W'(inc_r);
		end else if (ctl.drain) begin
			depth_q <= depth_in;
		end
	end

	assign r_out     = rs_q;
	assign l_out     = ls_q;
	assign depth_out = depth_q;

endmodule

>>> hw/rtl/cartesian_tree_depth_core.sv
// ----------------------------------------------------------------------------
// Cartesian tree depth core
// Takes a sequence of values and returns each position's depth in the
// max-rooted Cartesian tree, in input order.
// ----------------------------------------------------------------------------
// Loading accepts one word per cycle. After the final word, a setup state and
// then scan states step along the cell chain; a run of one skips the scan.
// Depths are then registered out of the head cell and leave one per cycle unless the receiver stalls.
// Input is stalled from the final word until the last depth is registered.
// Reset clears the control state and the count; stored values are undefined.
module cartesian_tree_depth_core
	import ctd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  ctd_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output ctd_out_t result
);

	ctd_state_t         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   step_q;
	logic               out_vld_q;
	ctd_out_t           out_q;
	ctd_ctl_t           ctl;
	logic               accept;
	logic               store;
	logic               out_load;

	ctd_stream_t        r_out [MAX_ITEMS];
	ctd_stream_t        l_out [MAX_ITEMS];
	logic [DEPTH_W-1:0] d_out [MAX_ITEMS];

	assign item_stall = (state_q != ST_LOAD);
	assign accept     = item_valid && !item_stall;
	assign store      = accept && (count_q < CNT_W'(MAX_ITEMS));
	assign out_load   = (state_q == ST_DRAIN) && (!out_vld_q || !result_stall);

	assign ctl.init  = (state_q == ST_INIT);
	assign ctl.scan  = (state_q == ST_SCAN);
	assign ctl.drain = out_load;

	generate
		for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
			ctd_stream_t        r_in;
			ctd_stream_t        l_in;
			logic [DEPTH_W-1:0] d_in;
			logic               wr;
			logic               occupied;

			if (i == 0) begin : g_first
				assign r_in = '0;
			end else begin : g_mid_l
				assign r_in = r_out[i-1];
			end
			if (i == MAX_ITEMS - 1) begin : g_last
				assign l_in = '0;
				assign d_in = '0;
			end else begin : g_mid_r
				assign l_in = l_out[i+1];
				assign d_in = d_out[i+1];
			end

			assign wr       = store && (count_q[IDX_W-1:0] == IDX_W'(i));
			assign occupied = (CNT_W'(i) < count_q);

			ctd_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.wr        (wr),
				.wr_value  (item.value[VALUE_BITS-1:0]),
				.occupied  (occupied),
				.r_in      (r_in),
				.l_in      (l_in),
				.depth_in  (d_in),
				.r_out     (r_out[i]),
				.l_out     (l_out[i]),
				.depth_out (d_out[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result_valid && !result_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (store) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (accept && item.is_final) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					// A single position needs no scan and drains from step zero.
					if (count_q == CNT_W'(1)) begin
						step_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						step_q  <= CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (step_q == count_q - CNT_W'(1)) begin
						step_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						if (step_q == count_q - CNT_W'(1)) begin
							step_q  <= '0;
							count_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							step_q <= step_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// During the drain, the head cell holds the depth of the next position to send.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.depth      <= d_out[0];
			out_q.end_of_run <= (step_q == count_q - CNT_W'(1));
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule

>>> sim/cartesian_tree_depth_core_tb.sv
// ----------------------------------------------------------------------------
// Cartesian tree depth core testbench
// Sends runs of values and checks each returned depth word against a
// predictor that counts the ancestors of every position. The runs are
// directed, random in length and shape, and overfull. The sender gaps and
// the receiver stalls are mixed over several phases.
// ----------------------------------------------------------------------------
module cartesian_tree_depth_core_tb;
	import ctd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 2 * MAX_ITEMS + 20;
	localparam int RANDOM_WORDS   = 10;
	localparam int MAX_REPORTS    = 10;

	typedef enum {SHAPE_RANDOM, SHAPE_FEW, SHAPE_RISING, SHAPE_FALLING, SHAPE_FLAT}
		run_shape_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_stall;
	ctd_in_t  item = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	ctd_out_t result;

	logic [VALUE_BITS-1:0] run_values [$];
	ctd_out_t              depth_queue [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int words_accepted = 0;
	int words_dropped = 0;
	int runs_closed = 0;
	int depths_checked = 0;
	int quiet_cycles = 0;
	int holdoff_left = 0;
	logic holdoff_req = 1'b0;
	logic holdoff_ack = 1'b0;

	cartesian_tree_depth_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Position i counts every j that is the leftmost maximum of the range
	// between them: ties on the left win, ties on the right do not.
	function automatic void predict_depths();
		int n;
		ctd_out_t want;
		n = run_values.size();
		for (int i = 0; i < n; i++) begin
			int cnt;
			logic [VALUE_BITS-1:0] peak;
			cnt = 0;
			peak = run_values[i];
			for (int j = i - 1; j >= 0; j--) begin
				if (run_values[j] >= peak) begin
					cnt++;
					peak = run_values[j];
				end
			end
			peak = run_values[i];
			for (int j = i + 1; j < n; j++) begin
				if (run_values[j] > peak) begin
					cnt++;
					peak = run_values[j];
				end
			end
			want.depth = cnt[DEPTH_W-1:0];
			want.end_of_run = (i == n - 1);
			depth_queue.push_back(want);
		end
		run_values.delete();
		runs_closed++;
	endfunction

	function automatic void log_mismatch(string msg);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endfunction

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			words_accepted++;
			if (run_values.size() < MAX_ITEMS)
				run_values.push_back(item.value[VALUE_BITS-1:0]);
			else
				words_dropped++;
			if (item.is_final)
				predict_depths();
		end
	end

	always @(posedge clk) begin
		ctd_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (depth_queue.size() == 0) begin
				log_mismatch($sformatf("unexpected word depth %0d end_of_run %0b",
					result.depth, result.end_of_run));
			end else begin
				want = depth_queue.pop_front();
				depths_checked++;
				if (result.depth !== want.depth)
					log_mismatch($sformatf("depth expected %0d got %0d",
						want.depth, result.depth));
				if (result.end_of_run !== want.end_of_run)
					log_mismatch($sformatf("end_of_run expected %0b got %0b",
						want.end_of_run, result.end_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("cartesian_tree_depth_core verification failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (holdoff_req != holdoff_ack) begin
			holdoff_ack <= holdoff_req;
			holdoff_left <= HOLDOFF_CYCLES;
			result_stall <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_word(input logic [15:0] v, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item.value <= v;
		item.is_final <= fin;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic release_input();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		release_input();
		while (depth_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_seq(input logic [15:0] seq [$]);
		for (int i = 0; i < seq.size(); i++)
			send_word(seq[i], i == seq.size() - 1);
	endtask

	task automatic send_random_run(input int len);
		run_shape_t shape;
		logic [15:0] base;
		logic [15:0] step;
		logic [15:0] v;
		shape = run_shape_t'($urandom_range(4));
		base = 16'($urandom);
		step = 16'($urandom_range(1, 300));
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_RANDOM:  v = 16'($urandom);
				SHAPE_FEW:     v = 16'($urandom_range(3));
				SHAPE_RISING:  v = 16'(base + step * i);
				SHAPE_FALLING: v = 16'(base - step * i);
				default:       v = base;
			endcase
			send_word(v, i == len - 1);
		end
	endtask

	task automatic test_directed();
		logic [15:0] seq [$];
		seq = {16'hFFFF};
		send_seq(seq);
		seq = {16'h0000};
		send_seq(seq);
		seq = {16'd7, 16'd7, 16'd7};
		send_seq(seq);
		seq = {16'd1, 16'd2, 16'd3, 16'd4};
		send_seq(seq);
		seq = {16'd4, 16'd3, 16'd2, 16'd1};
		send_seq(seq);
		seq = {16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF};
		send_seq(seq);
		seq = {16'd2, 16'd9, 16'd2, 16'd9, 16'd1, 16'd9};
		send_seq(seq);
		wait_drained();
	endtask

	// Mostly short runs; now and then one up to the full store.
	task automatic test_random_runs(input int words);
		int sent;
		int len;
		sent = 0;
		while (sent < words) begin
			if ($urandom_range(99) < 80)
				len = $urandom_range(1, 12);
			else
				len = $urandom_range(13, MAX_ITEMS);
			send_random_run(len);
			sent += len;
		end
		wait_drained();
	endtask

	// A run that exactly fills the store, then one whose tail and final word
	// are dropped while the flag still closes the run.
	task automatic test_store_full();
		send_random_run(MAX_ITEMS);
		send_random_run(MAX_ITEMS + 3);
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps offering runs, so the
	// block backs up and stalls its input.
	task automatic test_output_holdoff();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_req = ~holdoff_req;
		for (int r = 0; r < 2; r++)
			send_random_run($urandom_range(10, 20));
		wait_drained();
	endtask

	initial begin
		int idle_mix [4][2];
		idle_mix = '{'{0, 0}, '{66, 0}, '{0, 66}, '{36, 36}};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p][0];
			recv_stall_pct = idle_mix[p][1];
			test_random_runs(RANDOM_WORDS);
		end
		test_store_full();
		test_output_holdoff();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d runs, %0d words in (%0d dropped at a full store), %0d depths",
			runs_closed, words_accepted, words_dropped, depths_checked);
		$display("with sender gaps, receiver stalls, both, and a long output hold-off");
		if (mismatches == 0 && depth_queue.size() == 0) begin
			$display("cartesian_tree_depth_core verification clean");
		end else begin
			$display("%0d mismatches, %0d depths never arrived", mismatches,
				depth_queue.size());
			$display("cartesian_tree_depth_core verification failed");
		end
		$finish;
	end

endmodule
